FILE: hdl/pbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_pkg
// shared widths, constants and payload types of the prior box decoder
// ----------------------------------------------------------------------------
package pbd_pkg;

    // field widths
    localparam int unsigned DELTA_W   = 16;
    localparam int unsigned PRIOR_W   = 16;
    localparam int unsigned VAR_W     = 16;
    localparam int unsigned POS_W     = 20;
    localparam int unsigned SIZE_W    = 19;
    localparam int unsigned CFG_IDX_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_VARIANCE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_VARIANCE   = 4'd1;

    localparam logic [VAR_W-1:0] CENTER_VARIANCE_RST = 16'd6554;
    localparam logic [VAR_W-1:0] SIZE_VARIANCE_RST   = 16'd13107;

    // pipeline layout
    localparam int unsigned PIPE_STAGES = 9;
    localparam int unsigned EXP_STAGE0  = 3;
    localparam int unsigned EXP_STAGES  = 3;

    // exp table
    localparam int unsigned EXP_TABLE_ENTRIES_DEF = 256;
    localparam int unsigned POW2_W    = 32;
    localparam int unsigned POW2_FRAC = 30;
    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [63:0] ONE_Q30   = 64'h0000_0000_4000_0000;

    // datapath widths
    localparam int unsigned PROD1_W   = DELTA_W + VAR_W;
    localparam int unsigned PCP_W     = PROD1_W + PRIOR_W;
    localparam int unsigned CTR_SHIFT = 27;
    localparam int unsigned CENTER_W  = 22;
    localparam int unsigned YRAW_W    = 64;
    localparam int unsigned LOG_SHIFT = 30;
    localparam int unsigned LOG_W     = YRAW_W - LOG_SHIFT;
    localparam int unsigned FRAC_W    = 28;
    localparam int unsigned SHIFT_W   = LOG_W - FRAC_W;
    localparam int unsigned PROD_W    = PRIOR_W + POW2_W;
    localparam int unsigned RND_W     = PROD_W + 1;
    localparam int unsigned SCALE_W   = 31;
    localparam int unsigned DIFF_W    = SCALE_W + 2;

    localparam logic signed [YRAW_W-1:0]  LOG2E_Q30  = 64'sd1549082005;
    localparam logic signed [SHIFT_W:0]   SHIFT_BIAS = 7'sd29;
    localparam logic [SCALE_W-1:0]        SIZE_MAX   = 31'd524287;
    localparam logic signed [DIFF_W-1:0]  POS_MAX    = 33'sd524287;
    localparam logic signed [DIFF_W-1:0]  POS_MIN    = -33'sd524288;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic signed [DELTA_W-1:0] delta_w;
        logic signed [DELTA_W-1:0] delta_h;
        logic [PRIOR_W-1:0]        prior_cx;
        logic [PRIOR_W-1:0]        prior_cy;
        logic [PRIOR_W-1:0]        prior_w;
        logic [PRIOR_W-1:0]        prior_h;
    } pbd_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] box_left;
        logic signed [POS_W-1:0] box_top;
        logic [SIZE_W-1:0]       box_width;
        logic [SIZE_W-1:0]       box_height;
    } pbd_out_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [VAR_W-1:0]     data;
    } pbd_cfg_write_t;

    typedef struct packed {
        logic [VAR_W-1:0] center_variance;
        logic [VAR_W-1:0] size_variance;
    } variance_t;

endpackage

FILE: hdl/pbd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_stream_if
// valid/ready channel carrying one item of a given payload type
// ----------------------------------------------------------------------------
interface pbd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/prior_box_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prior_box_decoder_core
// fixed-point box decode with variances: offsets plus prior box in,
// top-left corner and size out
// ----------------------------------------------------------------------------
// Takes one item per clock while box.ready does not stall the pipeline, and
// returns one decoded box per item, in order. When the output side keeps
// ready high, an item passes through every stage without waiting. The
// datapath is nine register stages per axis (two axes side by side): offset
// times variance, times prior size or log2(e), rounding and center, table
// index, table read, interpolation, prior size times 2^y, rounding shift by
// the integer exponent, saturation. Each stage has its own valid bit and
// enable, so bubbles are squeezed out and a stall on box.ready back-pressures
// pred.ready without dropping or repeating an item. The exp table holds
// EXP_TABLE_ENTRIES+1 constant points of 2^(i/N), read as logic; there is
// no memory and no clearing pass after reset. pred.ready and cfg.ready stay
// low during reset; out of reset cfg.ready is always high, and variance
// writes take effect on the next cycle and belong in idle periods.
// ----------------------------------------------------------------------------
module prior_box_decoder_core
    import pbd_pkg::*;
#(
    parameter int unsigned EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    pbd_stream_if.sink    pred,
    pbd_stream_if.source  box,
    pbd_stream_if.sink    cfg
);

    variance_t              variance;
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] stage_en;

    // per-stage enable: a stage loads when empty or when its successor moves
    always_comb
    begin
        stage_en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || box.ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    // valid bits move with the data of each stage
    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = pred.valid;
        end
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // no item is taken while the valid bits are held in reset
    assign pred.ready = stage_en[0] && rst_n;
    assign box.valid  = valid_reg[PIPE_STAGES-1];

    // variance registers
    pbd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .variance (variance)
    );

    // x axis: left and width
    pbd_axis #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_axis_x (
        .clk      (clk),
        .stage_en (stage_en),
        .variance (variance),
        .delta_c  (pred.payload.delta_x),
        .delta_s  (pred.payload.delta_w),
        .prior_c  (pred.payload.prior_cx),
        .prior_s  (pred.payload.prior_w),
        .corner   (box.payload.box_left),
        .size     (box.payload.box_width)
    );

    // y axis: top and height
    pbd_axis #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_axis_y (
        .clk      (clk),
        .stage_en (stage_en),
        .variance (variance),
        .delta_c  (pred.payload.delta_y),
        .delta_s  (pred.payload.delta_h),
        .prior_c  (pred.payload.prior_cy),
        .prior_s  (pred.payload.prior_h),
        .corner   (box.payload.box_top),
        .size     (box.payload.box_height)
    );

    // a free output side never stalls the input
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        box.ready |-> pred.ready)
        else $error("input stalled while output side is ready");

    // a full pipeline with a stalled output takes no new item
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !box.ready |-> !pred.ready)
        else $error("item accepted into a full, stalled pipeline");

    // an item taken with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        box.valid && box.ready && !valid_reg[PIPE_STAGES-2] |=> !box.valid)
        else $error("output item repeated after it was taken");

endmodule

FILE: hdl/pbd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_cfg_regs
// center and size variance registers behind the write channel
// ----------------------------------------------------------------------------
module pbd_cfg_regs
    import pbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pbd_stream_if.sink   cfg,
    output variance_t    variance
);

    variance_t var_reg;
    variance_t var_next;

    // no write is taken while the registers are held in reset
    assign cfg.ready = rst_n;

    always_comb
    begin
        var_next = var_reg;
        if (cfg.valid)
        begin
            // unknown indexes are dropped
            if (cfg.payload.index == CFG_CENTER_VARIANCE)
            begin
                var_next.center_variance = cfg.payload.data;
            end
            if (cfg.payload.index == CFG_SIZE_VARIANCE)
            begin
                var_next.size_variance = cfg.payload.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_reg.center_variance <= CENTER_VARIANCE_RST;
            var_reg.size_variance   <= SIZE_VARIANCE_RST;
        end
        else
        begin
            var_reg <= var_next;
        end
    end

    assign variance = var_reg;

endmodule

FILE: hdl/pbd_exp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_exp_unit
// three-stage 2^f lookup with linear interpolation, f in [0,1) as Q.28
// ----------------------------------------------------------------------------
module pbd_exp_unit
    import pbd_pkg::*;
#(
    parameter int unsigned EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
)
(
    input  logic                  clk,
    input  logic [EXP_STAGES-1:0] stage_en,
    input  logic [FRAC_W-1:0]     frac,
    output logic [POW2_W-1:0]     pow2
);

    localparam int unsigned IDX_W  = $clog2(EXP_TABLE_ENTRIES);
    localparam int unsigned TBL_AW = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int unsigned SC_W   = FRAC_W + IDX_W;
    localparam int unsigned IP_W   = POW2_W + FRAC_W;

    typedef logic [POW2_W-1:0] pow2_tbl_t [0:EXP_TABLE_ENTRIES];

    // 2^(i/N) in Q1.30 from a truncated 20-term series of exp(i*ln2/N)
    function automatic logic [POW2_W-1:0] pow2_entry(input logic [63:0] i);
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] sum;
        t    = (i * LN2_Q30) / EXP_TABLE_ENTRIES;
        term = ONE_Q30;
        sum  = ONE_Q30;
        term = ((term * t) >> POW2_FRAC) / 64'd1;   sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd2;   sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd3;   sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd4;   sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd5;   sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd6;   sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd7;   sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd8;   sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd9;   sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd10;  sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd11;  sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd12;  sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd13;  sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd14;  sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd15;  sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd16;  sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd17;  sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd18;  sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd19;  sum = sum + term;
        term = ((term * t) >> POW2_FRAC) / 64'd20;  sum = sum + term;
        return POW2_W'(sum);
    endfunction

    function automatic pow2_tbl_t build_pow2_table();
        pow2_tbl_t tbl;
        for (int i = 0; i <= EXP_TABLE_ENTRIES; i++)
        begin
            tbl[i] = pow2_entry(64'(i));
        end
        return tbl;
    endfunction

    localparam pow2_tbl_t POW2_TABLE = build_pow2_table();

    logic [SC_W-1:0]   scaled;
    logic [TBL_AW-1:0] idx_reg;
    logic [TBL_AW-1:0] idx_next;
    logic [TBL_AW-1:0] idx_hi;
    logic [FRAC_W-1:0] wt_reg;
    logic [FRAC_W-1:0] wt_s1_reg;
    logic [POW2_W-1:0] lo_reg;
    logic [POW2_W-1:0] lo_next;
    logic [POW2_W-1:0] step_reg;
    logic [POW2_W-1:0] step_next;
    logic [IP_W-1:0]   interp;
    logic [POW2_W-1:0] pow2_reg;
    logic [POW2_W-1:0] pow2_next;

    // frac * N splits into table index and interpolation weight
    assign scaled   = SC_W'(frac) * SC_W'(EXP_TABLE_ENTRIES);
    assign idx_next = TBL_AW'(scaled[SC_W-1:FRAC_W]);

    assign idx_hi    = idx_reg + TBL_AW'(1);
    assign lo_next   = POW2_TABLE[idx_reg];
    assign step_next = POW2_TABLE[idx_hi] - POW2_TABLE[idx_reg];

    assign interp    = IP_W'(step_reg) * IP_W'(wt_s1_reg);
    assign pow2_next = lo_reg + interp[IP_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            idx_reg <= idx_next;
            wt_reg  <= scaled[FRAC_W-1:0];
        end
        if (stage_en[1])
        begin
            lo_reg    <= lo_next;
            step_reg  <= step_next;
            wt_s1_reg <= wt_reg;
        end
        if (stage_en[2])
        begin
            pow2_reg <= pow2_next;
        end
    end

    assign pow2 = pow2_reg;

endmodule

FILE: hdl/pbd_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_axis
// nine-stage decode of one axis: center, exp-scaled size, corner
// ----------------------------------------------------------------------------
module pbd_axis
    import pbd_pkg::*;
#(
    parameter int unsigned EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
)
(
    input  logic                    clk,
    input  logic [PIPE_STAGES-1:0]  stage_en,
    input  variance_t               variance,
    input  logic signed [DELTA_W-1:0] delta_c,
    input  logic signed [DELTA_W-1:0] delta_s,
    input  logic [PRIOR_W-1:0]      prior_c,
    input  logic [PRIOR_W-1:0]      prior_s,
    output logic signed [POS_W-1:0] corner,
    output logic [SIZE_W-1:0]       size
);

    // stage 0: offset times variance
    logic signed [PROD1_W-1:0] dc_ext, cv_ext, ds_ext, sv_ext;
    logic signed [PROD1_W-1:0] mc_reg, mc_next, ms_reg, ms_next;
    logic [PRIOR_W-1:0]        pc_reg [0:1];
    logic [PRIOR_W-1:0]        ps_reg [0:5];

    // stage 1: times prior size / times log2(e)
    logic signed [PCP_W-1:0]   pcp_reg, pcp_next;
    logic signed [YRAW_W-1:0]  yraw_reg, yraw_next;

    // stage 2: rounding, center
    logic [PCP_W-1:0]          c_round;
    logic [YRAW_W-1:0]         y_round;
    logic signed [CENTER_W-1:0] c16_reg [2:7];
    logic signed [CENTER_W-1:0] c16_next;
    logic signed [LOG_W-1:0]   y_reg, y_next;

    // stage 3 onward: exponent shift
    logic signed [SHIFT_W:0]   n_ext;
    logic [SHIFT_W-1:0]        sh_reg [3:6];
    logic [SHIFT_W-1:0]        sh_next;
    logic [POW2_W-1:0]         pow2;

    // stages 6..8
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [RND_W-1:0]          s_round;
    logic [SCALE_W-1:0]        s16_reg, s16_next;
    logic [SCALE_W:0]          w_sum;
    logic [SCALE_W-1:0]        half;
    logic signed [DIFF_W-1:0]  two_c, s_ext, r_sum, r_val;
    logic signed [POS_W-1:0]   corner_reg, corner_next;
    logic [SIZE_W-1:0]         size_reg, size_next;

    assign dc_ext  = PROD1_W'(delta_c);
    assign ds_ext  = PROD1_W'(delta_s);
    assign cv_ext  = $signed(PROD1_W'(variance.center_variance));
    assign sv_ext  = $signed(PROD1_W'(variance.size_variance));
    assign mc_next = dc_ext * cv_ext;
    assign ms_next = ds_ext * sv_ext;

    assign pcp_next  = PCP_W'(mc_reg) * $signed(PCP_W'(ps_reg[0]));
    assign yraw_next = YRAW_W'(ms_reg) * LOG2E_Q30;

    assign c_round  = pcp_reg + (PCP_W'(1) << (CTR_SHIFT - 1));
    assign c16_next = $signed(CENTER_W'({pc_reg[1], 1'b0}))
                    + CENTER_W'($signed(c_round[PCP_W-1:CTR_SHIFT]));
    assign y_round  = yraw_reg + (YRAW_W'(1) << (LOG_SHIFT - 1));
    assign y_next   = $signed(y_round[YRAW_W-1:LOG_SHIFT]);

    // integer part of the exponent sets the final right shift
    assign n_ext   = {y_reg[LOG_W-1], y_reg[LOG_W-1:FRAC_W]};
    assign sh_next = SHIFT_W'(SHIFT_BIAS - n_ext);

    pbd_exp_unit #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_exp (
        .clk      (clk),
        .stage_en (stage_en[EXP_STAGE0 +: EXP_STAGES]),
        .frac     (y_reg[FRAC_W-1:0]),
        .pow2     (pow2)
    );

    assign prod_next = PROD_W'(ps_reg[5]) * PROD_W'(pow2);

    assign s_round  = RND_W'(prod_reg) + (RND_W'(1) << (sh_reg[6] - SHIFT_W'(1)));
    assign s16_next = SCALE_W'(s_round >> sh_reg[6]);

    assign w_sum     = {1'b0, s16_reg} + {{SCALE_W{1'b0}}, 1'b1};
    assign half      = w_sum[SCALE_W:1];
    assign size_next = (half > SIZE_MAX) ? SIZE_MAX[SIZE_W-1:0] : half[SIZE_W-1:0];

    // corner from the unsaturated size, round half up by two bits
    assign two_c = DIFF_W'(c16_reg[7]) <<< 1;
    assign s_ext = $signed(DIFF_W'(s16_reg));
    assign r_sum = two_c - s_ext + $signed(DIFF_W'(2));
    assign r_val = r_sum >>> 2;

    always_comb
    begin
        priority if (r_val > POS_MAX)
        begin
            corner_next = $signed(POS_MAX[POS_W-1:0]);
        end
        else if (r_val < POS_MIN)
        begin
            corner_next = $signed(POS_MIN[POS_W-1:0]);
        end
        else
        begin
            corner_next = $signed(r_val[POS_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            mc_reg    <= mc_next;
            ms_reg    <= ms_next;
            pc_reg[0] <= prior_c;
            ps_reg[0] <= prior_s;
        end
        if (stage_en[1])
        begin
            pcp_reg   <= pcp_next;
            yraw_reg  <= yraw_next;
            pc_reg[1] <= pc_reg[0];
            ps_reg[1] <= ps_reg[0];
        end
        if (stage_en[2])
        begin
            c16_reg[2] <= c16_next;
            y_reg      <= y_next;
            ps_reg[2]  <= ps_reg[1];
        end
        if (stage_en[3])
        begin
            sh_reg[3] <= sh_next;
        end
        for (int k = 3; k <= 5; k++)
        begin
            if (stage_en[k])
            begin
                ps_reg[k] <= ps_reg[k-1];
            end
        end
        for (int k = 3; k <= 7; k++)
        begin
            if (stage_en[k])
            begin
                c16_reg[k] <= c16_reg[k-1];
            end
        end
        for (int k = 4; k <= 6; k++)
        begin
            if (stage_en[k])
            begin
                sh_reg[k] <= sh_reg[k-1];
            end
        end
        if (stage_en[6])
        begin
            prod_reg <= prod_next;
        end
        if (stage_en[7])
        begin
            s16_reg <= s16_next;
        end
        if (stage_en[8])
        begin
            corner_reg <= corner_next;
            size_reg   <= size_next;
        end
    end

    assign corner = corner_reg;
    assign size   = size_reg;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for prior_box_decoder_core
// ----------------------------------------------------------------------------
// Feeds offset sets with their prior boxes into the decoder and predicts each
// decoded box in the bench. The prediction uses its own pow2 table and its
// own copy of the variance registers. Every box that leaves the block is
// checked field by field against the oldest prediction. The run goes through
// six variance settings: reset values, zero, full scale, random, skewed, and
// back to default. Sender and receiver idle at random, and one long receiver
// stall fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top
    import pbd_pkg::*;
();

    localparam int unsigned  TABLE_N            = EXP_TABLE_ENTRIES_DEF;
    localparam longint       LOG2E_FIX          = 64'sd1549082005;
    localparam longint       LN2_FIX            = 64'sd744261118;
    localparam longint       CORNER_MAX         = 64'sd524287;
    localparam longint       CORNER_MIN         = -64'sd524288;
    localparam longint       EXTENT_MAX         = 64'sd524287;
    localparam int unsigned  RANDOM_PER_PHASE   = 150;
    localparam int unsigned  LONG_STALL_CYCLES  = 80;
    localparam longint       TIMEOUT_NS         = 64'd3_000_000;
    // index past the register list; the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 4'd7;

    logic clk;
    logic rst_n;

    pbd_stream_if #(.T(pbd_in_t))        pred_if ();
    pbd_stream_if #(.T(pbd_out_t))       box_if ();
    pbd_stream_if #(.T(pbd_cfg_write_t)) cfg_if ();

    prior_box_decoder_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pred  (pred_if),
        .box   (box_if),
        .cfg   (cfg_if)
    );

    // bench copy of the variance registers and the 2^(i/N) table in Q1.30
    logic [VAR_W-1:0]    center_var;
    logic [VAR_W-1:0]    size_var;
    longint unsigned     pow2_points [0:TABLE_N];

    pbd_in_t             offsets_to_send [$];
    pbd_out_t            boxes_due [$];

    int unsigned         send_idle_pct = 0;
    int unsigned         recv_idle_pct = 0;
    logic                recv_hold = 1'b0;
    event                start_long_stall;

    int unsigned         error_count = 0;
    int unsigned         boxes_checked = 0;
    int unsigned         settings_used = 0;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // truncated Taylor series of exp(i*ln2/N), every term truncated
    task automatic fill_pow2_points();
        longint unsigned t;
        longint unsigned sum;
        longint unsigned term;
        for (int i = 0; i <= TABLE_N; i++)
        begin
            t    = (longint'(i) * LN2_FIX) / TABLE_N;
            sum  = 64'd1 << 30;
            term = 64'd1 << 30;
            for (int k = 1; k <= 20; k++)
            begin
                term = ((term * t) >> 30) / k;
                sum  = sum + term;
            end
            pow2_points[i] = sum;
        end
    endtask

    // floor((v + 2^(s-1)) / 2^s), round half up
    function automatic longint round_shift(input longint v, input int unsigned s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // one axis: center offset and log size offset against prior center and size
    function automatic void decode_axis(input logic signed [DELTA_W-1:0] d_ctr,
                                        input logic signed [DELTA_W-1:0] d_size,
                                        input logic [PRIOR_W-1:0]        p_ctr,
                                        input logic [PRIOR_W-1:0]        p_size,
                                        output logic signed [POS_W-1:0]  corner,
                                        output logic [SIZE_W-1:0]        extent);
        longint          center16;
        longint          y;
        longint          n;
        longint          corner_q;
        longint unsigned frac;
        longint unsigned scaled;
        longint unsigned idx;
        longint unsigned wt;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned e;
        longint unsigned prod;
        longint unsigned size16;
        longint unsigned half;
        int unsigned     sh;

        center16 = 2 * longint'(p_ctr)
                 + round_shift(longint'(d_ctr) * longint'(center_var) * longint'(p_size), 27);

        // log2 of the size factor, Q.28; split into integer exponent and fraction
        y      = round_shift(longint'(d_size) * longint'(size_var) * LOG2E_FIX, 30);
        n      = y >>> 28;
        frac   = longint'(y) & ((64'd1 << 28) - 1);
        scaled = frac * TABLE_N;
        idx    = scaled >> 28;
        wt     = scaled & ((64'd1 << 28) - 1);
        if (idx >= TABLE_N)
            idx = TABLE_N - 1;
        lo = pow2_points[idx];
        hi = pow2_points[idx + 1];
        e  = lo + (((hi - lo) * wt) >> 28);

        prod   = longint'(p_size) * e;
        sh     = 32'(29 - n);
        size16 = (prod + (64'd1 << (sh - 1))) >> sh;

        half = (size16 + 1) >> 1;
        if (half > EXTENT_MAX)
            half = EXTENT_MAX;

        // corner uses the unsaturated size
        corner_q = round_shift(2 * center16 - longint'(size16), 2);
        if (corner_q > CORNER_MAX)
            corner_q = CORNER_MAX;
        if (corner_q < CORNER_MIN)
            corner_q = CORNER_MIN;

        corner = corner_q[POS_W-1:0];
        extent = half[SIZE_W-1:0];
    endfunction

    function automatic pbd_out_t decode_prior_box(input pbd_in_t item);
        pbd_out_t res;
        decode_axis(item.delta_x, item.delta_w, item.prior_cx, item.prior_w,
                    res.box_left, res.box_width);
        decode_axis(item.delta_y, item.delta_h, item.prior_cy, item.prior_h,
                    res.box_top, res.box_height);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // reporting
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic check_field(input string field_name, input longint got,
                               input longint want);
        if (got != want)
            flag_mismatch($sformatf("box %0d %s: got %0d, want %0d",
                                    boxes_checked, field_name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // offset driver: holds an item until accepted, idles at random
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pred_if.valid   <= 1'b0;
            pred_if.payload <= '0;
        end
        else if (!pred_if.valid || pred_if.ready)
        begin
            if (offsets_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pred_if.valid   <= 1'b1;
                pred_if.payload <= offsets_to_send.pop_front();
            end
            else
            begin
                pred_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // box receiver: random idling, plus the long hold-off when requested
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            box_if.ready <= 1'b0;
        else
            box_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver stall, counted here so the stimulus keeps feeding
    initial
    begin
        forever
        begin
            @(start_long_stall);
            recv_hold <= 1'b1;
            repeat (LONG_STALL_CYCLES) @(posedge clk);
            recv_hold <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on item acceptance, checks on box acceptance,
    // tracks register writes
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pbd_out_t want;
        if (!rst_n)
        begin
            center_var <= CENTER_VARIANCE_RST;
            size_var   <= SIZE_VARIANCE_RST;
        end
        else
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.payload.index)
                    CFG_CENTER_VARIANCE: center_var <= cfg_if.payload.data;
                    CFG_SIZE_VARIANCE:   size_var   <= cfg_if.payload.data;
                    default: ;
                endcase
            end

            if (pred_if.valid && pred_if.ready)
                boxes_due.insert(boxes_due.size(), decode_prior_box(pred_if.payload));

            if (box_if.valid && box_if.ready)
            begin
                if (boxes_due.size() == 0)
                begin
                    flag_mismatch("box with no item waiting for it");
                end
                else
                begin
                    want = boxes_due.pop_front();
                    check_field("box_left",   longint'(box_if.payload.box_left),
                                longint'(want.box_left));
                    check_field("box_top",    longint'(box_if.payload.box_top),
                                longint'(want.box_top));
                    check_field("box_width",  longint'(box_if.payload.box_width),
                                longint'(want.box_width));
                    check_field("box_height", longint'(box_if.payload.box_height),
                                longint'(want.box_height));
                end
                boxes_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic pbd_in_t make_item(input int dx, input int dy, input int dw,
                                          input int dh, input int cx, input int cy,
                                          input int pw, input int ph);
        pbd_in_t item;
        item.delta_x  = dx[DELTA_W-1:0];
        item.delta_y  = dy[DELTA_W-1:0];
        item.delta_w  = dw[DELTA_W-1:0];
        item.delta_h  = dh[DELTA_W-1:0];
        item.prior_cx = cx[PRIOR_W-1:0];
        item.prior_cy = cy[PRIOR_W-1:0];
        item.prior_w  = pw[PRIOR_W-1:0];
        item.prior_h  = ph[PRIOR_W-1:0];
        return item;
    endfunction

    // appends one item to the tail of the send queue
    task automatic queue_item(input pbd_in_t item);
        offsets_to_send.insert(offsets_to_send.size(), item);
    endtask

    function automatic int edge_delta();
        case ($urandom_range(4))
            0:       return 0;
            1:       return 1;
            2:       return -1;
            3:       return 32767;
            default: return -32768;
        endcase
    endfunction

    function automatic int edge_prior();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 1;
            2:       return 32768;
            default: return 65535;
        endcase
    endfunction

    // mostly realistic offsets around a sane prior, some raw noise, some corners
    function automatic pbd_in_t random_item();
        case ($urandom_range(5))
            0:
                return make_item($urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom);
            1:
                return make_item(edge_delta(), edge_delta(), edge_delta(), edge_delta(),
                                 edge_prior(), edge_prior(), edge_prior(), edge_prior());
            default:
                return make_item(int'($urandom_range(8192)) - 4096,
                                 int'($urandom_range(8192)) - 4096,
                                 int'($urandom_range(12288)) - 6144,
                                 int'($urandom_range(12288)) - 6144,
                                 $urandom_range(32768), $urandom_range(32768),
                                 $urandom_range(1, 32768), $urandom_range(1, 32768));
        endcase
    endfunction

    // extremes of every field, zero prior sizes, unit and tiny values
    task automatic queue_directed_items();
        queue_item(make_item(0, 0, 0, 0, 0, 0, 0, 0));
        queue_item(make_item(32767, 32767, 32767, 32767,
                             65535, 65535, 65535, 65535));
        queue_item(make_item(-32768, -32768, -32768, -32768,
                             65535, 65535, 65535, 65535));
        // zero prior size: corner sits on the center
        queue_item(make_item(32767, -32768, 32767, -32768,
                             0, 65535, 0, 65535));
        queue_item(make_item(-32768, 32767, -32768, 32767,
                             65535, 0, 65535, 0));
        queue_item(make_item(4096, 4096, 4096, 4096,
                             16384, 16384, 16384, 16384));
        queue_item(make_item(0, 0, 0, 0, 32768, 32768, 0, 0));
        queue_item(make_item(1, -1, 1, -1, 1, 1, 1, 1));
    endtask

    // wait on settled values at the falling edge until every box is back
    task automatic wait_until_drained();
        @(negedge clk);
        while (offsets_to_send.size() != 0 || pred_if.valid || boxes_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [VAR_W-1:0] data);
        @(posedge clk);
        cfg_if.valid           <= 1'b1;
        cfg_if.payload.index   <= index;
        cfg_if.payload.data    <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // one variance setting: idle, reprogram if asked, then feed a batch of items
    task automatic run_phase(input bit write_cfg, input logic [VAR_W-1:0] cv,
                             input logic [VAR_W-1:0] sv, input int unsigned send_pct,
                             input int unsigned recv_pct, input bit with_directed,
                             input bit with_stall);
        wait_until_drained();
        if (write_cfg)
        begin
            write_register(CFG_CENTER_VARIANCE, cv);
            write_register(CFG_SIZE_VARIANCE, sv);
        end
        @(posedge clk);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
        @(negedge clk);
        if (with_directed)
            queue_directed_items();
        repeat (RANDOM_PER_PHASE)
            queue_item(random_item());
        settings_used++;
        if (with_stall)
        begin
            repeat (5) @(posedge clk);
            -> start_long_stall;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        fill_pow2_points();

        rst_n           = 1'b0;
        cfg_if.valid    <= 1'b0;
        cfg_if.payload  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset variances, then zero variances (exp is exactly one), receiver slow
        run_phase(1'b0, '0, '0, 31, 83, 1'b1, 1'b0);
        run_phase(1'b1, 16'd0, 16'd0, 31, 83, 1'b1, 1'b0);
        // full-scale variances drive the size into saturation, sender slow
        run_phase(1'b1, 16'hFFFF, 16'hFFFF, 83, 31, 1'b1, 1'b0);
        run_phase(1'b1, VAR_W'($urandom_range(65535)), VAR_W'($urandom_range(65535)),
                  83, 31, 1'b0, 1'b0);
        // no idling; long receiver stall backs the pipeline up into the input
        run_phase(1'b1, 16'd1, 16'hFFFF, 0, 0, 1'b0, 1'b1);

        // a write past the register list must leave the variances alone
        wait_until_drained();
        write_register(CFG_UNUSED_INDEX, VAR_W'($urandom_range(65535)));
        run_phase(1'b1, CENTER_VARIANCE_RST, SIZE_VARIANCE_RST, 0, 0, 1'b0, 1'b0);

        wait_until_drained();
        repeat (2 * PIPE_STAGES + 4) @(posedge clk);

        $display("summary: %0d decoded boxes checked over %0d variance settings",
                 boxes_checked, settings_used);
        $display("summary: edge offsets, zero priors, saturation, idle gaps, long stall");
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout: %0d boxes still outstanding", boxes_due.size());
        $display("tb_top failed");
        $finish;
    end

endmodule
